[rtl/hvtp_pkg.sv]
package hvtp_pkg;

  localparam int SCORE_WIDTH = 32;
  localparam int NUM_MODELS  = 8;
  localparam int MAX_STATES  = 8;
  localparam int DATA_WIDTH  = 32;
  localparam int BEAM_WIDTH  = 31;
  localparam int MCOUNT_WIDTH = 4;

  typedef logic signed [SCORE_WIDTH-1:0] score_t;

  localparam score_t LOG_ZERO  = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam score_t LOG_SMALL = {2'b11, {(SCORE_WIDTH-2){1'b0}}};
  localparam score_t SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
  localparam logic [BEAM_WIDTH-1:0] DEFAULT_BEAM = BEAM_WIDTH'(300 * 1024);
  localparam logic [MCOUNT_WIDTH-1:0] DEFAULT_MCOUNT = MCOUNT_WIDTH'(8);

  typedef enum logic [2:0] {
    FN_LOAD_TRANS = 3'd0,
    FN_LOAD_SIZE  = 3'd1,
    FN_START      = 3'd2,
    FN_EMIT       = 3'd3,
    FN_STEP       = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    CFG_PENALTY = 2'd0,
    CFG_BEAM    = 2'd1,
    CFG_MCOUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN_ADDR,
    ST_SCAN_EVAL,
    ST_STATE_DONE,
    ST_COPY,
    ST_MODEL_DONE,
    ST_THRESH,
    ST_ENTRY,
    ST_FINISH
  } seq_state_t;

  // Saturating add in which log zero absorbs.
  function automatic score_t sat_add(score_t a, score_t b);
    logic signed [SCORE_WIDTH:0] s;
    s = {a[SCORE_WIDTH-1], a} + {b[SCORE_WIDTH-1], b};
    if (a == LOG_ZERO || b == LOG_ZERO) begin
      sat_add = LOG_ZERO;
    end else if (s[SCORE_WIDTH] != s[SCORE_WIDTH-1]) begin
      sat_add = s[SCORE_WIDTH] ? LOG_ZERO : SCORE_MAX;
    end else begin
      sat_add = s[SCORE_WIDTH-1:0];
    end
  endfunction

  // Sign-extends a 32-bit word and saturates it to the score width.
  function automatic score_t from_word(logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] x;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    x  = {{(64-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    hi = 64'(SCORE_MAX);
    lo = 64'(LOG_ZERO);
    if (x > hi) begin
      from_word = SCORE_MAX;
    end else if (x < lo) begin
      from_word = LOG_ZERO;
    end else begin
      from_word = x[SCORE_WIDTH-1:0];
    end
  endfunction

  // Saturates a score to a 32-bit word.
  function automatic logic [DATA_WIDTH-1:0] to_word(score_t s);
    logic signed [63:0] x;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    x  = 64'(s);
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      to_word = 32'h7FFF_FFFF;
    end else if (x < lo) begin
      to_word = 32'h8000_0000;
    end else begin
      to_word = x[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

[rtl/hvtp_if.sv]
interface hvtp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  model;
  logic [2:0]  from_state;
  logic [2:0]  to_state;
  logic signed [31:0] value;

  modport source (output valid, func, model, from_state, to_state, value, input ready);
  modport sink   (input valid, func, model, from_state, to_state, value, output ready);
endinterface

interface hvtp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] best_score;
  logic [2:0]  best_model;
  logic signed [31:0] word_end_score;
  logic [2:0]  word_end_model;
  logic        word_end_found;

  modport source (output valid, best_score, best_model, word_end_score, word_end_model,
                  word_end_found, input ready);
  modport sink   (input valid, best_score, best_model, word_end_score, word_end_model,
                  word_end_found, output ready);
endinterface

[rtl/hvtp_score_mem.sv]
module hvtp_score_mem #(
  parameter int DEPTH = hvtp_pkg::NUM_MODELS * hvtp_pkg::MAX_STATES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  hvtp_pkg::score_t    wdata,
  input  logic [AW-1:0]       raddr,
  input  logic                rentry,
  output hvtp_pkg::score_t    rdata
);

  hvtp_pkg::score_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  hvtp_pkg::score_t q_r;
  logic             vq_r;
  logic             entry_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r       <= mem[raddr];
    vq_r      <= valid_r[raddr];
    entry_q_r <= rentry;
  end

  // An entry that was never written since the last clear reads as its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = vq_r ? q_r : (entry_q_r ? '0 : hvtp_pkg::LOG_ZERO);

endmodule

[rtl/hmm_viterbi_token_passing_core.sv]
// Viterbi token passing over up to NUM_MODELS left-to-right word models with beam pruning.
// Requests arrive on in_chan (valid/ready); a request is taken when both are high. Loads of
// transitions, model sizes and emissions, and the start of an utterance, complete in the
// cycle they are taken and give no result. A step-frame request gives one result on out_chan.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this. A frame is worked by one
// add-compare-select unit, one predecessor at a time through an address state and an
// evaluate state. Models are worked in turn, one of under two states is skipped, and the
// frame ends with threshold and entry tokens. in_chan.ready stays low for the whole frame.
// The result sits in an output register; if the receiver stalls, the block waits once the
// next frame is done, but takes load requests meanwhile.
// Reset clears all tokens to log zero with entry tokens at zero, sets the threshold to log
// small and the registers to their defaults; transition and emission stores are not cleared.
module hmm_viterbi_token_passing_core #(
  parameter int NUM_MODELS = hvtp_pkg::NUM_MODELS,
  parameter int MAX_STATES = hvtp_pkg::MAX_STATES
) (
  input  logic        clk,
  input  logic        rst_n,
  hvtp_in_if.sink     in_chan,
  hvtp_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW   = hvtp_pkg::SCORE_WIDTH;
  localparam int MW   = $clog2(NUM_MODELS + 1);
  localparam int MI   = (NUM_MODELS > 1) ? $clog2(NUM_MODELS) : 1;
  localparam int CW   = $clog2(MAX_STATES + 1);
  localparam int SI   = $clog2(MAX_STATES);
  localparam int TOKW = $clog2(NUM_MODELS * MAX_STATES);
  localparam int TRN  = NUM_MODELS * MAX_STATES * MAX_STATES;
  localparam int TRW  = $clog2(TRN);
  localparam int DW   = ((SW > hvtp_pkg::BEAM_WIDTH) ? SW : hvtp_pkg::BEAM_WIDTH) + 2;

  hvtp_pkg::seq_state_t state_r, state_nxt;

  logic signed [31:0]                pen_r;
  logic [hvtp_pkg::BEAM_WIDTH-1:0]   beam_r;
  logic [hvtp_pkg::MCOUNT_WIDTH-1:0] mcount_r;

  logic [MW-1:0] m_r, m_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          exit_r, exit_nxt;
  logic          found_r, found_nxt;
  hvtp_pkg::score_t run_r, run_nxt;
  hvtp_pkg::score_t com_r, com_nxt;
  hvtp_pkg::score_t mmax_r, mmax_nxt;
  hvtp_pkg::score_t gbest_r, gbest_nxt;
  logic [MW-1:0]    gmod_r, gmod_nxt;
  hvtp_pkg::score_t wbest_r, wbest_nxt;
  logic [MW-1:0]    wmod_r, wmod_nxt;
  logic             wfound_r, wfound_nxt;
  hvtp_pkg::score_t thr_r, thr_nxt;
  hvtp_pkg::score_t entry_r, entry_nxt;

  logic [CW-1:0]    mstates_r [NUM_MODELS];
  hvtp_pkg::score_t scratch_r [MAX_STATES];

  hvtp_pkg::score_t trans_mem [TRN];
  hvtp_pkg::score_t emis_mem  [NUM_MODELS * MAX_STATES];
  hvtp_pkg::score_t trans_q_r;
  hvtp_pkg::score_t emis_q_r;

  logic             out_valid_r;
  logic [31:0]      out_best_r;
  logic [2:0]       out_bmod_r;
  logic [31:0]      out_wend_r;
  logic [2:0]       out_wmod_r;
  logic             out_found_r;

  logic             in_fire;
  logic             out_load;
  hvtp_pkg::score_t in_score;
  logic [CW-1:0]    in_size;
  logic             trans_we, emis_we, size_we, scr_we, tok_we, tok_clear;
  logic [TRW-1:0]   trans_wa;
  logic [TOKW-1:0]  emis_wa;
  logic [SI-1:0]    scr_idx;
  hvtp_pkg::score_t scr_d;
  logic [TOKW-1:0]  tok_wa;
  hvtp_pkg::score_t tok_wd;
  logic [TOKW-1:0]  tok_ra;
  logic [TRW-1:0]   trans_ra;
  logic [TOKW-1:0]  emis_ra;
  hvtp_pkg::score_t tok_rd;
  logic [MW-1:0]    used;
  logic [CW-1:0]    cur_size;
  hvtp_pkg::score_t term, run_max, best, emit_sum;
  logic             pred_live;
  logic signed [DW-1:0] g_ext, b_ext, diff, small_ext;
  hvtp_pkg::score_t thr_new;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == hvtp_pkg::ST_IDLE);

  assign in_score = hvtp_pkg::from_word(in_chan.value);
  always_comb begin
    if (in_score < 0) begin
      in_size = '0;
    end else if (in_score > MAX_STATES) begin
      in_size = CW'(MAX_STATES);
    end else begin
      in_size = in_score[CW-1:0];
    end
  end

  assign used = (int'(mcount_r) > NUM_MODELS) ? MW'(NUM_MODELS) : MW'(mcount_r);
  assign cur_size = mstates_r[m_r[MI-1:0]];

  assign tok_ra   = TOKW'(int'(m_r) * MAX_STATES + int'(i_r));
  assign trans_ra = TRW'((int'(m_r) * MAX_STATES + int'(i_r)) * MAX_STATES + int'(j_r));
  assign emis_ra  = TOKW'(int'(m_r) * MAX_STATES + int'(j_r));

  assign term      = hvtp_pkg::sat_add(tok_rd, trans_q_r);
  assign pred_live = trans_q_r > hvtp_pkg::LOG_SMALL;
  assign run_max   = (run_r > term) ? run_r : term;
  assign best      = found_r ? com_r : hvtp_pkg::LOG_ZERO;
  assign emit_sum  = hvtp_pkg::sat_add(best, emis_q_r);

  assign g_ext     = DW'(gbest_r);
  assign b_ext     = DW'(beam_r);
  assign diff      = g_ext - b_ext;
  assign small_ext = DW'(hvtp_pkg::LOG_SMALL);
  assign thr_new   = (diff < small_ext) ? hvtp_pkg::LOG_SMALL : diff[SW-1:0];

  hvtp_score_mem #(
    .DEPTH (NUM_MODELS * MAX_STATES),
    .AW    (TOKW)
  ) u_tokens (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (tok_clear),
    .we     (tok_we),
    .waddr  (tok_wa),
    .wdata  (tok_wd),
    .raddr  (tok_ra),
    .rentry (i_r == '0),
    .rdata  (tok_rd)
  );

  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    exit_nxt   = exit_r;
    found_nxt  = found_r;
    run_nxt    = run_r;
    com_nxt    = com_r;
    mmax_nxt   = mmax_r;
    gbest_nxt  = gbest_r;
    gmod_nxt   = gmod_r;
    wbest_nxt  = wbest_r;
    wmod_nxt   = wmod_r;
    wfound_nxt = wfound_r;
    thr_nxt    = thr_r;
    entry_nxt  = entry_r;
    trans_we   = 1'b0;
    trans_wa   = TRW'((int'(in_chan.model) * MAX_STATES + int'(in_chan.from_state))
                      * MAX_STATES + int'(in_chan.to_state));
    emis_we    = 1'b0;
    emis_wa    = TOKW'(int'(in_chan.model) * MAX_STATES + int'(in_chan.to_state));
    size_we    = 1'b0;
    scr_we     = 1'b0;
    scr_idx    = j_r[SI-1:0];
    scr_d      = hvtp_pkg::LOG_ZERO;
    tok_we     = 1'b0;
    tok_wa     = tok_ra;
    tok_wd     = scratch_r[i_r[SI-1:0]];
    tok_clear  = 1'b0;
    out_load   = 1'b0;

    case (state_r)
      hvtp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.func)
            hvtp_pkg::FN_LOAD_TRANS: begin
              trans_we = (int'(in_chan.model) < NUM_MODELS) &&
                         (int'(in_chan.from_state) < MAX_STATES) &&
                         (int'(in_chan.to_state) < MAX_STATES);
            end
            hvtp_pkg::FN_LOAD_SIZE: begin
              size_we = int'(in_chan.model) < NUM_MODELS;
            end
            hvtp_pkg::FN_START: begin
              tok_clear = 1'b1;
              thr_nxt   = hvtp_pkg::LOG_SMALL;
            end
            hvtp_pkg::FN_EMIT: begin
              emis_we = (int'(in_chan.model) < NUM_MODELS) &&
                        (int'(in_chan.to_state) < MAX_STATES);
            end
            hvtp_pkg::FN_STEP: begin
              m_nxt      = '0;
              gbest_nxt  = hvtp_pkg::LOG_ZERO;
              gmod_nxt   = '0;
              wbest_nxt  = hvtp_pkg::LOG_ZERO;
              wmod_nxt   = '0;
              wfound_nxt = 1'b0;
              state_nxt  = hvtp_pkg::ST_SETUP;
            end
            default: begin
            end
          endcase
        end
      end

      hvtp_pkg::ST_SETUP: begin
        if (m_r >= used) begin
          state_nxt = hvtp_pkg::ST_THRESH;
        end else if (cur_size < CW'(2)) begin
          m_nxt = m_r + MW'(1);
        end else begin
          n_nxt    = cur_size - CW'(1);
          mmax_nxt = hvtp_pkg::LOG_ZERO;
          scr_we   = 1'b1;
          scr_idx  = '0;
          i_nxt    = '0;
          found_nxt = 1'b0;
          exit_nxt = 1'b0;
          if (cur_size > CW'(2)) begin
            j_nxt     = CW'(1);
            state_nxt = hvtp_pkg::ST_SCAN_ADDR;
          end else begin
            state_nxt = hvtp_pkg::ST_COPY;
          end
        end
      end

      hvtp_pkg::ST_SCAN_ADDR: begin
        state_nxt = hvtp_pkg::ST_SCAN_EVAL;
      end

      // The span opens at the first strong predecessor and reaches the last strong one
      // above index one; once it has opened, predecessors up to index one lie inside it.
      hvtp_pkg::ST_SCAN_EVAL: begin
        if (!found_r) begin
          if (pred_live) begin
            found_nxt = 1'b1;
            run_nxt   = term;
            com_nxt   = term;
          end
        end else begin
          run_nxt = run_max;
          if (pred_live || i_r <= CW'(1)) begin
            com_nxt = run_max;
          end
        end
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == n_r) begin
          state_nxt = exit_r ? hvtp_pkg::ST_MODEL_DONE : hvtp_pkg::ST_STATE_DONE;
        end else begin
          state_nxt = hvtp_pkg::ST_SCAN_ADDR;
        end
      end

      hvtp_pkg::ST_STATE_DONE: begin
        scr_we = 1'b1;
        if (best > thr_r) begin
          scr_d = emit_sum;
          if (emit_sum > mmax_r) begin
            mmax_nxt = emit_sum;
          end
        end
        j_nxt     = j_r + CW'(1);
        i_nxt     = '0;
        found_nxt = 1'b0;
        if (j_r + CW'(1) == n_r) begin
          state_nxt = hvtp_pkg::ST_COPY;
        end else begin
          state_nxt = hvtp_pkg::ST_SCAN_ADDR;
        end
      end

      hvtp_pkg::ST_COPY: begin
        tok_we = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (i_r + CW'(1) == n_r) begin
          found_nxt = 1'b0;
          if (n_r > CW'(1)) begin
            exit_nxt  = 1'b1;
            j_nxt     = n_r;
            i_nxt     = CW'(1);
            state_nxt = hvtp_pkg::ST_SCAN_ADDR;
          end else begin
            state_nxt = hvtp_pkg::ST_MODEL_DONE;
          end
        end
      end

      hvtp_pkg::ST_MODEL_DONE: begin
        if (mmax_r > gbest_r) begin
          gbest_nxt = mmax_r;
          gmod_nxt  = m_r;
        end
        if (best > hvtp_pkg::LOG_SMALL) begin
          wfound_nxt = 1'b1;
          if (best > wbest_r) begin
            wbest_nxt = best;
            wmod_nxt  = m_r;
          end
        end
        m_nxt     = m_r + MW'(1);
        state_nxt = hvtp_pkg::ST_SETUP;
      end

      hvtp_pkg::ST_THRESH: begin
        thr_nxt   = thr_new;
        entry_nxt = hvtp_pkg::sat_add(wbest_r, hvtp_pkg::from_word(pen_r));
        m_nxt     = '0;
        state_nxt = (wbest_r > thr_new) ? hvtp_pkg::ST_ENTRY : hvtp_pkg::ST_FINISH;
      end

      hvtp_pkg::ST_ENTRY: begin
        i_nxt = '0;
        if (m_r >= used) begin
          state_nxt = hvtp_pkg::ST_FINISH;
        end else begin
          tok_we = cur_size >= CW'(2);
          tok_wa = TOKW'(int'(m_r) * MAX_STATES);
          tok_wd = entry_r;
          m_nxt  = m_r + MW'(1);
        end
      end

      hvtp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = hvtp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hvtp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hvtp_pkg::ST_IDLE;
      thr_r    <= hvtp_pkg::LOG_SMALL;
      pen_r    <= '0;
      beam_r   <= hvtp_pkg::DEFAULT_BEAM;
      mcount_r <= hvtp_pkg::DEFAULT_MCOUNT;
    end else begin
      state_r <= state_nxt;
      thr_r   <= thr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          hvtp_pkg::CFG_PENALTY: pen_r    <= cfg_data;
          hvtp_pkg::CFG_BEAM:    beam_r   <= cfg_data[hvtp_pkg::BEAM_WIDTH-1:0];
          hvtp_pkg::CFG_MCOUNT:  mcount_r <= cfg_data[hvtp_pkg::MCOUNT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    exit_r   <= exit_nxt;
    found_r  <= found_nxt;
    run_r    <= run_nxt;
    com_r    <= com_nxt;
    mmax_r   <= mmax_nxt;
    gbest_r  <= gbest_nxt;
    gmod_r   <= gmod_nxt;
    wbest_r  <= wbest_nxt;
    wmod_r   <= wmod_nxt;
    wfound_r <= wfound_nxt;
    entry_r  <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MODELS; k++) begin
        mstates_r[k] <= '0;
      end
    end else if (size_we) begin
      mstates_r[MI'(in_chan.model)] <= in_size;
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scratch_r[scr_idx] <= scr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_wa] <= in_score;
    end
    trans_q_r <= trans_mem[trans_ra];
  end

  always_ff @(posedge clk) begin
    if (emis_we) begin
      emis_mem[emis_wa] <= in_score;
    end
    emis_q_r <= emis_mem[emis_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_r  <= hvtp_pkg::to_word(gbest_r);
      out_bmod_r  <= 3'(gmod_r);
      out_wend_r  <= hvtp_pkg::to_word(wbest_r);
      out_wmod_r  <= 3'(wmod_r);
      out_found_r <= wfound_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.best_score     = out_best_r;
  assign out_chan.best_model     = out_bmod_r;
  assign out_chan.word_end_score = out_wend_r;
  assign out_chan.word_end_model = out_wmod_r;
  assign out_chan.word_end_found = out_found_r;

endmodule

[rtl/hvtp_checker.sv]
module hvtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_we_score,
  input logic [2:0]  out_we_model
);

  // A finished result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A frame request blocks further requests while it is worked.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == hvtp_pkg::FN_STEP |=> !in_ready)
    else $error("request taken during a frame");

  // A new result only appears at the end of a frame.
  a_out_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a frame");

  // Without a word end the word-end fields read log zero and model zero.
  a_no_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_we_score == 32'h8000_0000 && out_we_model == 3'd0)
    else $error("word-end fields set without a word end");

endmodule

bind hmm_viterbi_token_passing_core hvtp_checker u_hvtp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_func      (in_chan.func),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_found    (out_chan.word_end_found),
  .out_we_score (out_chan.word_end_score),
  .out_we_model (out_chan.word_end_model)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam longint LZ = -64'sd2147483648;
  localparam longint LSMALL = -64'sd1073741824;
  localparam longint SMAXL = 64'sd2147483647;
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 3000;
  localparam int PHASE_ITEMS = 40;
  localparam int NM = hvtp_pkg::NUM_MODELS;
  localparam int MS = hvtp_pkg::MAX_STATES;

  typedef struct packed {
    logic signed [31:0] best_score;
    logic [2:0]         best_model;
    logic signed [31:0] word_end_score;
    logic [2:0]         word_end_model;
    logic               word_end_found;
  } frame_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         model;
    logic [2:0]         from_state;
    logic [2:0]         to_state;
    logic signed [31:0] value;
  } request_t;

  typedef struct {
    request_t req;
    bit       fixed;
    frame_t   res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  hvtp_pkg::cfg_idx_t cfg_index;
  logic [31:0] cfg_data;

  hvtp_in_if  in_if ();
  hvtp_out_if out_if ();

  hmm_viterbi_token_passing_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow state of the recogniser.
  longint trans_lp [NM][MS][MS];
  longint emit_lp [NM][MS];
  longint tokens [NM][MS];
  int     states_n [NM];
  longint threshold;
  longint penalty;
  longint beam;
  int     models_used;

  frame_t frame_results_q[$];
  row_t   rows[$];
  int     errors;
  int     quiet_cycles;
  bit     idle_on;
  bit     hold_long;

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    if (a == LZ || b == LZ) return LZ;
    s = a + b;
    if (s > SMAXL) return SMAXL;
    if (s < LZ) return LZ;
    return s;
  endfunction

  function automatic longint best_pred(int m, int j, int n, int first);
    int lo;
    int hi;
    longint b;
    longint c;
    lo = first;
    while (lo < n && trans_lp[m][lo][j] <= LSMALL) lo++;
    if (lo >= n) return LZ;
    hi = n - 1;
    while (hi > 1 && trans_lp[m][hi][j] <= LSMALL) hi--;
    b = sat_sum(tokens[m][lo], trans_lp[m][lo][j]);
    for (int i = lo + 1; i <= hi; i++) begin
      c = sat_sum(tokens[m][i], trans_lp[m][i][j]);
      if (c > b) b = c;
    end
    return b;
  endfunction

  function automatic void clear_utterance();
    foreach (tokens[m, k]) tokens[m][k] = (k == 0) ? 0 : LZ;
    threshold = LSMALL;
  endfunction

  function automatic frame_t step_frame_model();
    frame_t r;
    longint gbest;
    longint wbest;
    longint mmax;
    longint t;
    longint ex;
    longint thr;
    longint scratch [MS];
    int gmod;
    int wmod;
    int used;
    int n;
    bit found;
    gbest = LZ;
    wbest = LZ;
    gmod = 0;
    wmod = 0;
    found = 0;
    used = (models_used > NM) ? NM : models_used;
    for (int m = 0; m < used; m++) begin
      if (states_n[m] < 2) continue;
      n = states_n[m] - 1;
      mmax = LZ;
      scratch[0] = LZ;
      for (int j = 1; j < n; j++) begin
        t = best_pred(m, j, n, 0);
        if (t > threshold) begin
          t = sat_sum(t, emit_lp[m][j]);
          if (t > mmax) mmax = t;
        end else begin
          t = LZ;
        end
        scratch[j] = t;
      end
      for (int k = 0; k < n; k++) tokens[m][k] = scratch[k];
      if (mmax > gbest) begin
        gbest = mmax;
        gmod = m;
      end
      ex = best_pred(m, n, n, 1);
      if (ex > LSMALL) begin
        found = 1;
        if (ex > wbest) begin
          wbest = ex;
          wmod = m;
        end
      end
    end
    thr = gbest - beam;
    if (thr < LSMALL) thr = LSMALL;
    threshold = thr;
    if (wbest > thr) begin
      for (int m = 0; m < used; m++) begin
        if (states_n[m] >= 2) tokens[m][0] = sat_sum(wbest, penalty);
      end
    end
    r.best_score = 32'(gbest);
    r.best_model = 3'(gmod);
    r.word_end_score = 32'(wbest);
    r.word_end_model = 3'(wmod);
    r.word_end_found = found;
    return r;
  endfunction

  // Applies one accepted request to the shadow state; returns 1 if it gives a frame result.
  function automatic bit apply_request(request_t q, output frame_t r);
    longint v;
    v = longint'(q.value);
    r = '0;
    case (q.func)
      hvtp_pkg::FN_LOAD_TRANS: trans_lp[q.model][q.from_state][q.to_state] = v;
      hvtp_pkg::FN_LOAD_SIZE:
        states_n[q.model] = (v < 0) ? 0 : ((v > MS) ? MS : int'(v));
      hvtp_pkg::FN_START: clear_utterance();
      hvtp_pkg::FN_EMIT: emit_lp[q.model][q.to_state] = v;
      hvtp_pkg::FN_STEP: begin
        r = step_frame_model();
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_row(request_t q, bit fixed, frame_t res);
    rows.insert(rows.size(), '{q, fixed, res});
  endtask

  task automatic send_request(request_t q, bit fixed, frame_t want);
    int gap;
    frame_t r;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func <= q.func;
    in_if.model <= q.model;
    in_if.from_state <= q.from_state;
    in_if.to_state <= q.to_state;
    in_if.value <= q.value;
    do @(posedge clk); while (!in_if.ready);
    if (apply_request(q, r)) frame_results_q.insert(frame_results_q.size(), fixed ? want : r);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(longint pen, longint bw, int mc);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= hvtp_pkg::CFG_PENALTY;
    cfg_data <= 32'(pen);
    penalty = longint'(signed'(32'(pen)));
    @(posedge clk);
    cfg_index <= hvtp_pkg::CFG_BEAM;
    cfg_data <= 32'(bw);
    beam = longint'(bw) & 64'h7FFF_FFFF;
    @(posedge clk);
    cfg_index <= hvtp_pkg::CFG_MCOUNT;
    cfg_data <= 32'(mc);
    models_used = mc & 15;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_logprob();
    case ($urandom_range(0, 9))
      0: return 32'(LZ);
      1: return 32'(LSMALL);
      2: return $urandom();
      3: return 32'(SMAXL);
      4: return 32'(LSMALL + 1);
      default: return 32'(-longint'($urandom_range(0, 8000)));
    endcase
  endfunction

  function automatic logic [31:0] rand_emission();
    case ($urandom_range(0, 11))
      0: return 32'(LZ);
      1: return 32'(SMAXL);
      2: return $urandom();
      default: return 32'(-longint'($urandom_range(0, 20000)));
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t q;
    int pick;
    q.func = hvtp_pkg::FN_STEP;
    q.model = 3'($urandom());
    q.from_state = 3'($urandom());
    q.to_state = 3'($urandom());
    q.value = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 35) q.func = hvtp_pkg::FN_STEP;
    else if (pick < 60) begin
      q.func = hvtp_pkg::FN_LOAD_TRANS;
      q.value = rand_logprob();
    end else if (pick < 80) begin
      q.func = hvtp_pkg::FN_EMIT;
      q.value = rand_emission();
    end else if (pick < 90) begin
      q.func = hvtp_pkg::FN_LOAD_SIZE;
      if ($urandom_range(0, 4) != 0) q.value = $urandom_range(0, 9);
    end else if (pick < 95) q.func = hvtp_pkg::FN_START;
    else q.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    return q;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= hvtp_pkg::CFG_PENALTY;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.func <= hvtp_pkg::FN_START;
    in_if.model <= '0;
    in_if.from_state <= '0;
    in_if.to_state <= '0;
    in_if.value <= '0;
    out_if.ready <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    frame_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (hold_long) begin
        hold_long = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (frame_results_q.size() == 0) begin
        report_mismatch("results outstanding", 0, 1);
      end else begin
        want = frame_results_q.pop_front();
        if (out_if.best_score !== want.best_score)
          report_mismatch("best_score", out_if.best_score, want.best_score);
        if (out_if.best_model !== want.best_model)
          report_mismatch("best_model", out_if.best_model, want.best_model);
        if (out_if.word_end_score !== want.word_end_score)
          report_mismatch("word_end_score", out_if.word_end_score, want.word_end_score);
        if (out_if.word_end_model !== want.word_end_model)
          report_mismatch("word_end_model", out_if.word_end_model, want.word_end_model);
        if (out_if.word_end_found !== want.word_end_found)
          report_mismatch("word_end_found", out_if.word_end_found, want.word_end_found);
      end
    end
  end

  initial begin
    frame_t none;
    request_t q;
    longint pens [5];
    longint beams [5];
    int counts [5];
    errors = 0;
    idle_on = 1'b1;
    hold_long = 1'b0;
    foreach (trans_lp[m, i, j]) trans_lp[m][i][j] = 0;
    foreach (emit_lp[m, j]) emit_lp[m][j] = 0;
    foreach (states_n[m]) states_n[m] = 0;
    clear_utterance();
    penalty = 0;
    beam = 64'(hvtp_pkg::DEFAULT_BEAM);
    models_used = 8;
    none.best_score = 32'(LZ);
    none.best_model = '0;
    none.word_end_score = 32'(LZ);
    none.word_end_model = '0;
    none.word_end_found = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every store entry is written before any model is given a size.
    for (int m = 0; m < NM; m++) begin
      for (int i = 0; i < MS; i++) begin
        for (int j = 0; j < MS; j++) begin
          q = '{hvtp_pkg::FN_LOAD_TRANS, 3'(m), 3'(i), 3'(j), rand_logprob()};
          send_request(q, 1'b0, none);
        end
        q = '{hvtp_pkg::FN_EMIT, 3'(m), 3'($urandom()), 3'(i), rand_emission()};
        send_request(q, 1'b0, none);
      end
    end

    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b1, none);
    add_row('{FN_SPARE_LO, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF}, 1'b0, none);
    add_row('{FN_SPARE_HI, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_SIZE, 3'd0, 3'd0, 3'd0, -32'sd5}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_SIZE, 3'd1, 3'd0, 3'd0, 32'sd1}, 1'b0, none);
    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b1, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd2, 3'd0, 3'd1, 32'sd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd2, 3'd1, 3'd1, -32'sd700}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd2, 3'd1, 3'd2, -32'sd300}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd2, 3'd0, 3'd2, 32'sd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_EMIT, 3'd2, 3'd0, 3'd1, -32'sd1024}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_SIZE, 3'd2, 3'd0, 3'd0, 32'sd3}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_SIZE, 3'd4, 3'd0, 3'd0, 32'h7FFF_FFFF}, 1'b0, none);
    add_row('{hvtp_pkg::FN_START, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_EMIT, 3'd4, 3'd0, 3'd3, 32'h7FFF_FFFF}, 1'b0, none);
    add_row('{hvtp_pkg::FN_EMIT, 3'd4, 3'd0, 3'd2, 32'h8000_0000}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd4, 3'd2, 3'd3, 32'h7FFF_FFFF}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_TRANS, 3'd4, 3'd0, 3'd7, 32'h8000_0000}, 1'b0, none);
    add_row('{hvtp_pkg::FN_LOAD_SIZE, 3'd7, 3'd0, 3'd0, 32'sd2}, 1'b0, none);
    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_START, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    add_row('{hvtp_pkg::FN_STEP, 3'd0, 3'd0, 3'd0, 32'd0}, 1'b0, none);
    foreach (rows[r]) send_request(rows[r].req, rows[r].fixed, rows[r].res);
    wait_drained();

    pens = '{0, -64'sd2147483648, 64'sd2147483647, -64'sd3000, longint'($urandom_range(0, 5000))};
    beams = '{64'(hvtp_pkg::DEFAULT_BEAM), 0, 64'sd2147483647, 64'sd20480,
              longint'($urandom_range(0, 400000))};
    counts = '{8, 1, 15, 0, $urandom_range(2, 8)};
    for (int p = 0; p < 5; p++) begin
      write_config(pens[p], beams[p], counts[p]);
      idle_on = (p != 2);
      hold_long = (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) send_request(rand_request(), 1'b0, none);
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hvtp_pkg.sv
rtl/hvtp_if.sv
rtl/hvtp_score_mem.sv
rtl/hmm_viterbi_token_passing_core.sv
rtl/hvtp_checker.sv
tb/tb_top.sv
